FILE: src/szps_pkg.sv
// Package for the scrolled, zoomed palette scan-out.
// Holds command and register codes, field widths, the pipeline item type,
// the zoom reciprocal table and the remainder step; no dependencies.
package szps_pkg;

    typedef enum logic [1:0] {
        CMD_SCAN    = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_PALETTE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DISPLAY_WIDTH  = 3'd0,
        REG_DISPLAY_HEIGHT = 3'd1,
        REG_SCROLL_X       = 3'd2,
        REG_SCROLL_Y       = 3'd3,
        REG_ZOOM_X         = 3'd4,
        REG_ZOOM_Y         = 3'd5
    } cfg_reg_t;

    localparam int CMD_W       = 2;
    localparam int COORD_W     = 9;
    localparam int DIM_W       = 10;
    localparam int SCROLL_W    = 9;
    localparam int ZOOM_W      = 5;
    localparam int COLOUR_W    = 8;
    localparam int INDEX_W     = 8;
    localparam int CFG_W       = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int DIM_RESET   = 512;

    // floor(n / z) == (n * ceil(2^14 / z)) >> 14 for every 9-bit n and z up to 31
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = 15;
    localparam int PROD_W      = COORD_W + RECIP_W;
    localparam int ZOOM_CODES  = 32;
    localparam int ZOOM_RESET  = 1;

    localparam logic [RECIP_W-1:0] RECIP_TABLE [ZOOM_CODES] = '{
        15'd16384, 15'd16384, 15'd8192, 15'd5462, 15'd4096, 15'd3277, 15'd2731, 15'd2341,
        15'd2048,  15'd1821,  15'd1639, 15'd1490, 15'd1366, 15'd1261, 15'd1171, 15'd1093,
        15'd1024,  15'd964,   15'd911,  15'd863,  15'd820,  15'd781,  15'd745,  15'd713,
        15'd683,   15'd656,   15'd631,  15'd607,  15'd586,  15'd565,  15'd547,  15'd529
    };

    localparam int MOD_STEPS_PER_STAGE = 2;
    localparam int MOD_STAGES          = DIM_W / MOD_STEPS_PER_STAGE;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  line;
        logic [INDEX_W-1:0]  index_value;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } item_t;

    // One restoring step: subtract the divisor shifted by k when it fits
    function automatic logic [DIM_W-1:0] mod_step(
        input logic [DIM_W-1:0] r,
        input logic [DIM_W-1:0] d,
        input int unsigned      k
    );
        logic [2*DIM_W-1:0] dk;
        dk = (2*DIM_W)'(d) << k;
        if ({{DIM_W{1'b0}}, r} >= dk)
            return r - dk[DIM_W-1:0];
        return r;
    endfunction

endpackage

FILE: src/szps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low; no dependencies.
module szps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/scrolled_zoomed_palette_scanout.sv
// Scrolled, zoomed palette scan-out: the top level and its pipeline.
// Depends on szps_pkg and on szps_ram for the frame store and the palette.
//
// Usage:
// - Command channel (cmd_valid / cmd_stall): one transaction per scan pixel,
//   frame store write or palette write, taken when cmd_valid is high and
//   cmd_stall is low.
// - Pixel channel (pixel_valid / pixel_stall): one colour transaction per
//   scan command, in command order; writes and unused codes give none.
// - Configuration: cfg_we writes cfg_data to register cfg_index; write it
//   only while no command is in flight.
// - Throughput: one command per cycle while pixel_stall is low. Path from
//   acceptance to pixel_valid: the multiply stage, the scroll add stage,
//   five remainder stages of two restoring steps each, the wrap stage, the
//   address multiply stage, the frame store read and the palette read.
// - Pixel stall: each stage holds only while it is full and the one after
//   it holds, so empty stages still fill and cmd_stall rises only when the
//   pipeline is full back to the input.
// - Reset: clears all valid bits and restores the registers to width and
//   height 512 (or the maximum), no scroll and zoom 1. The frame store and
//   palette are not cleared.
module scrolled_zoomed_palette_scanout #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_HEIGHT      = 512,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic [szps_pkg::CMD_W-1:0]           command,
    input  logic [szps_pkg::COORD_W-1:0]         column,
    input  logic [szps_pkg::COORD_W-1:0]         line,
    input  logic [szps_pkg::INDEX_W-1:0]         index_value,
    input  logic [szps_pkg::COLOUR_W-1:0]        red_in,
    input  logic [szps_pkg::COLOUR_W-1:0]        green_in,
    input  logic [szps_pkg::COLOUR_W-1:0]        blue_in,

    output logic                                 pixel_valid,
    input  logic                                 pixel_stall,
    output logic [szps_pkg::COLOUR_W-1:0]        red_out,
    output logic [szps_pkg::COLOUR_W-1:0]        green_out,
    output logic [szps_pkg::COLOUR_W-1:0]        blue_out,

    input  logic                                 cfg_we,
    input  logic [szps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [szps_pkg::CFG_W-1:0]           cfg_data
);

    localparam int DIM_W      = szps_pkg::DIM_W;
    localparam int COORD_W    = szps_pkg::COORD_W;
    localparam int PROD_W     = szps_pkg::PROD_W;
    localparam int MOD_STAGES = szps_pkg::MOD_STAGES;
    localparam int COLOUR_W   = szps_pkg::COLOUR_W;
    localparam int INDEX_W    = szps_pkg::INDEX_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PAL_AW      = $clog2(PALETTE_ENTRIES);
    localparam int PAL_KEYS    = 1 << INDEX_W;
    localparam int LIMIT_W     = DIM_W + 1;

    localparam logic [DIM_W-1:0] WIDTH_RESET =
        DIM_W'((szps_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : szps_pkg::DIM_RESET);
    localparam logic [DIM_W-1:0] HEIGHT_RESET =
        DIM_W'((szps_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : szps_pkg::DIM_RESET);

    function automatic logic [PAL_KEYS*PAL_AW-1:0] pal_map_table();
        logic [PAL_KEYS*PAL_AW-1:0] t;
        t = '0;
        for (int i = 0; i < PAL_KEYS; i++)
        begin
            t[i*PAL_AW +: PAL_AW] = PAL_AW'(i % PALETTE_ENTRIES);
        end
        return t;
    endfunction

    localparam logic [PAL_KEYS*PAL_AW-1:0] PAL_MAP = pal_map_table();

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]                    display_width_reg;
    logic [DIM_W-1:0]                    display_height_reg;
    logic [szps_pkg::SCROLL_W-1:0]       scroll_x_reg;
    logic [szps_pkg::SCROLL_W-1:0]       scroll_y_reg;
    logic [szps_pkg::RECIP_W-1:0]        recip_x_reg;
    logic [szps_pkg::RECIP_W-1:0]        recip_y_reg;
    logic [DIM_W-1:0]                    display_width_next;
    logic [DIM_W-1:0]                    display_height_next;

    always_comb
    begin
        if (cfg_data == '0)
            display_width_next = DIM_W'(1);
        else if (LIMIT_W'(cfg_data) > LIMIT_W'(MAX_WIDTH))
            display_width_next = DIM_W'(MAX_WIDTH);
        else
            display_width_next = cfg_data;

        if (cfg_data == '0)
            display_height_next = DIM_W'(1);
        else if (LIMIT_W'(cfg_data) > LIMIT_W'(MAX_HEIGHT))
            display_height_next = DIM_W'(MAX_HEIGHT);
        else
            display_height_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_width_reg  <= WIDTH_RESET;
            display_height_reg <= HEIGHT_RESET;
            scroll_x_reg       <= '0;
            scroll_y_reg       <= '0;
            recip_x_reg        <= szps_pkg::RECIP_TABLE[szps_pkg::ZOOM_RESET];
            recip_y_reg        <= szps_pkg::RECIP_TABLE[szps_pkg::ZOOM_RESET];
        end
        else if (cfg_we)
        begin
            case (szps_pkg::cfg_reg_t'(cfg_index))
                szps_pkg::REG_DISPLAY_WIDTH:  display_width_reg  <= display_width_next;
                szps_pkg::REG_DISPLAY_HEIGHT: display_height_reg <= display_height_next;
                szps_pkg::REG_SCROLL_X:       scroll_x_reg <= cfg_data[szps_pkg::SCROLL_W-1:0];
                szps_pkg::REG_SCROLL_Y:       scroll_y_reg <= cfg_data[szps_pkg::SCROLL_W-1:0];
                szps_pkg::REG_ZOOM_X:
                    recip_x_reg <= szps_pkg::RECIP_TABLE[cfg_data[szps_pkg::ZOOM_W-1:0]];
                szps_pkg::REG_ZOOM_Y:
                    recip_y_reg <= szps_pkg::RECIP_TABLE[cfg_data[szps_pkg::ZOOM_W-1:0]];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when empty or when its successor does
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic c_valid_reg;
    logic d_valid_reg;
    logic e_valid_reg;
    logic f_valid_reg;
    logic mod_valid_reg [MOD_STAGES+1];
    logic en_mod        [MOD_STAGES+1];
    logic en_a;
    logic en_c;
    logic en_d;
    logic en_e;
    logic en_f;

    assign en_f = !f_valid_reg || !pixel_stall;
    assign en_e = !e_valid_reg || en_f;
    assign en_d = !d_valid_reg || en_e;
    assign en_c = !c_valid_reg || en_d;
    assign en_mod[MOD_STAGES] = !mod_valid_reg[MOD_STAGES] || en_c;

    for (genvar i = 0; i < MOD_STAGES; i++)
    begin : g_en
        assign en_mod[i] = !mod_valid_reg[i] || en_mod[i+1];
    end

    assign en_a      = !a_valid_reg || en_mod[0];
    assign cmd_stall = !en_a;

    // ------------------------------------------------------------------
    // Stage A: capture and scale by the zoom reciprocals
    // ------------------------------------------------------------------
    szps_pkg::item_t   a_item_reg;
    logic [PROD_W-1:0] a_prod_x_reg;
    logic [PROD_W-1:0] a_prod_y_reg;
    logic [PROD_W-1:0] a_prod_x_next;
    logic [PROD_W-1:0] a_prod_y_next;

    assign a_prod_x_next = PROD_W'(column) * PROD_W'(recip_x_reg);
    assign a_prod_y_next = PROD_W'(line) * PROD_W'(recip_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en_a)
            a_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_item_reg   <= '{command: command, column: column, line: line,
                              index_value: index_value, red: red_in,
                              green: green_in, blue: blue_in};
            a_prod_x_reg <= a_prod_x_next;
            a_prod_y_reg <= a_prod_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Remainder pipeline: x sum mod width, zoomed row and scroll mod height
    // ------------------------------------------------------------------
    szps_pkg::item_t  mod_item_reg [MOD_STAGES+1];
    logic [DIM_W-1:0] rem_x_reg    [MOD_STAGES+1];
    logic [DIM_W-1:0] rem_a_reg    [MOD_STAGES+1];
    logic [DIM_W-1:0] rem_b_reg    [MOD_STAGES+1];
    logic [COORD_W-1:0] quot_x;
    logic [COORD_W-1:0] quot_y;

    assign quot_x = a_prod_x_reg[szps_pkg::RECIP_SHIFT +: COORD_W];
    assign quot_y = a_prod_y_reg[szps_pkg::RECIP_SHIFT +: COORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_valid_reg[0] <= 1'b0;
        else if (en_mod[0])
            mod_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_mod[0])
        begin
            mod_item_reg[0] <= a_item_reg;
            rem_x_reg[0]    <= DIM_W'(quot_x) + DIM_W'(scroll_x_reg);
            rem_a_reg[0]    <= DIM_W'(quot_y);
            rem_b_reg[0]    <= DIM_W'(scroll_y_reg);
        end
    end

    for (genvar s = 1; s <= MOD_STAGES; s++)
    begin : g_mod
        logic [DIM_W-1:0] rem_x_next;
        logic [DIM_W-1:0] rem_a_next;
        logic [DIM_W-1:0] rem_b_next;

        always_comb
        begin
            rem_x_next = rem_x_reg[s-1];
            rem_a_next = rem_a_reg[s-1];
            rem_b_next = rem_b_reg[s-1];
            for (int j = szps_pkg::MOD_STEPS_PER_STAGE - 1; j >= 0; j--)
            begin
                rem_x_next = szps_pkg::mod_step(rem_x_next, display_width_reg,
                    unsigned'(szps_pkg::MOD_STEPS_PER_STAGE * (MOD_STAGES - s) + j));
                rem_a_next = szps_pkg::mod_step(rem_a_next, display_height_reg,
                    unsigned'(szps_pkg::MOD_STEPS_PER_STAGE * (MOD_STAGES - s) + j));
                rem_b_next = szps_pkg::mod_step(rem_b_next, display_height_reg,
                    unsigned'(szps_pkg::MOD_STEPS_PER_STAGE * (MOD_STAGES - s) + j));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                mod_valid_reg[s] <= 1'b0;
            else if (en_mod[s])
                mod_valid_reg[s] <= mod_valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en_mod[s])
            begin
                mod_item_reg[s] <= mod_item_reg[s-1];
                rem_x_reg[s]    <= rem_x_next;
                rem_a_reg[s]    <= rem_a_next;
                rem_b_reg[s]    <= rem_b_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: wrap the row difference and flip the row
    // ------------------------------------------------------------------
    szps_pkg::item_t  c_item_reg;
    logic [DIM_W-1:0] c_x_reg;
    logic [DIM_W-1:0] c_srow_reg;
    logic [DIM_W-1:0] c_y_next;
    logic [DIM_W-1:0] c_srow_next;

    always_comb
    begin
        if (rem_a_reg[MOD_STAGES] >= rem_b_reg[MOD_STAGES])
            c_y_next = rem_a_reg[MOD_STAGES] - rem_b_reg[MOD_STAGES];
        else
            c_y_next = display_height_reg - (rem_b_reg[MOD_STAGES] - rem_a_reg[MOD_STAGES]);
        c_srow_next = display_height_reg - DIM_W'(1) - c_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en_c)
            c_valid_reg <= mod_valid_reg[MOD_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_item_reg <= mod_item_reg[MOD_STAGES];
            c_x_reg    <= rem_x_reg[MOD_STAGES];
            c_srow_reg <= c_srow_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: frame store address for scan or write
    // ------------------------------------------------------------------
    szps_pkg::item_t   d_item_reg;
    logic [ADDR_W-1:0] d_addr_reg;
    logic              d_store_we_reg;
    logic [ADDR_W-1:0] d_addr_next;
    logic              d_store_we_next;
    logic [DIM_W-1:0]  row_sel;
    logic [DIM_W-1:0]  col_sel;
    logic              c_is_scan;

    assign c_is_scan = c_item_reg.command == szps_pkg::CMD_SCAN;

    always_comb
    begin
        if (c_is_scan)
        begin
            row_sel = c_srow_reg;
            col_sel = c_x_reg;
        end
        else
        begin
            row_sel = DIM_W'(c_item_reg.line);
            col_sel = DIM_W'(c_item_reg.column);
        end
        d_addr_next = ADDR_W'(row_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);
        d_store_we_next = (c_item_reg.command == szps_pkg::CMD_STORE)
                       && (LIMIT_W'(c_item_reg.column) < LIMIT_W'(MAX_WIDTH))
                       && (LIMIT_W'(c_item_reg.line) < LIMIT_W'(MAX_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en_d)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_item_reg     <= c_item_reg;
            d_addr_reg     <= d_addr_next;
            d_store_we_reg <= d_store_we_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: frame store access
    // ------------------------------------------------------------------
    szps_pkg::item_t    e_item_reg;
    logic               frame_we;
    logic [INDEX_W-1:0] frame_rd_data;

    assign frame_we = d_valid_reg && d_store_we_reg && en_e;

    szps_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (frame_we),
        .wr_addr (d_addr_reg),
        .wr_data (d_item_reg.index_value),
        .rd_en   (en_e),
        .rd_addr (d_addr_reg),
        .rd_data (frame_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en_e)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
            e_item_reg <= d_item_reg;
    end

    // ------------------------------------------------------------------
    // Stage F: palette access, result register
    // ------------------------------------------------------------------
    logic                  e_is_scan;
    logic                  pal_we;
    logic [INDEX_W-1:0]    pal_key;
    logic [PAL_AW-1:0]     pal_addr;
    logic [3*COLOUR_W-1:0] pal_rd_data;

    assign e_is_scan = e_item_reg.command == szps_pkg::CMD_SCAN;
    assign pal_key   = e_is_scan ? frame_rd_data : e_item_reg.index_value;
    assign pal_addr  = PAL_MAP[int'(pal_key) * PAL_AW +: PAL_AW];
    assign pal_we    = e_valid_reg && (e_item_reg.command == szps_pkg::CMD_PALETTE) && en_f;

    szps_ram #(
        .WIDTH (3 * COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pal_addr),
        .wr_data ({e_item_reg.red, e_item_reg.green, e_item_reg.blue}),
        .rd_en   (en_f),
        .rd_addr (pal_addr),
        .rd_data (pal_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en_f)
            f_valid_reg <= e_valid_reg && e_is_scan;
    end

    assign pixel_valid = f_valid_reg;
    assign red_out     = pal_rd_data[2*COLOUR_W +: COLOUR_W];
    assign green_out   = pal_rd_data[COLOUR_W +: COLOUR_W];
    assign blue_out    = pal_rd_data[0 +: COLOUR_W];

`ifndef ASSERT_OFF
    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        mod_valid_reg[MOD_STAGES] |->
            (rem_x_reg[MOD_STAGES] < display_width_reg)
            && (rem_a_reg[MOD_STAGES] < display_height_reg)
            && (rem_b_reg[MOD_STAGES] < display_height_reg))
        else $error("remainder not reduced below modulus");

    a_frame_we_store: assert property (@(posedge clk) disable iff (!rst_n)
        frame_we |-> (d_item_reg.command == szps_pkg::CMD_STORE))
        else $error("frame store written by a non-store transaction");

    a_pixel_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid) |-> $past(e_valid_reg && e_is_scan))
        else $error("pixel produced without a scan transaction");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (a_valid_reg && mod_valid_reg[0] && f_valid_reg && pixel_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
